// ----- hw/rtl/tbk_pkg.sv -----
package tbk_pkg;

  // Per-list command bundle from the controller to a list datapath.
  typedef struct packed {
    logic scan_clr;   // restart the best-entry tracker
    logic rd_en;      // read one stored entry at rd_idx
    logic pick_top;   // scan for the strongest unmarked entry, else the weakest entry
    logic wr_append;  // store the new item at the fill position
    logic wr_repl;    // overwrite the weakest entry if the new item beats it
    logic wr_sorted;  // copy the tracked entry into the spare bank, mark it
    logic swap;       // spare bank becomes the live bank, clear marks
  } cmd_t;

  typedef logic signed [15:0] score_t;
  typedef logic [31:0]        tag_t;

  // True when a is strictly better than b for the given list flavor.
  function automatic logic beats(input logic keep_high, input score_t a, input score_t b);
    beats = keep_high ? (a > b) : (a < b);
  endfunction

endpackage

// ----- hw/rtl/top_bottom_k_score_tracker.sv -----
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     req_type, score, position_tag
// out_      output     out_valid / out_stall   list_select, rank, entry_score, entry_tag, last
//
// One item is worked at a time; in_stall is low only when the controller is idle.
// Record: per list an append while filling, or a scan for the weakest entry and a replace once full,
//   after an idle-to-start step; both lists are handled in turn through one read port each.
// Dump: per non-empty list with n entries, n ranks, each waiting while out_stall holds the output;
//   each rank is one full scan of the list memory through its one read port.
// Reset (synchronous, rst_n low) empties both lists; stored entries need no clearing.
// out_stall holds the output register and freezes the dump sequencer at its next result.
module top_bottom_k_score_tracker #(
  parameter int HIGH_DEPTH = 8,
  parameter int LOW_DEPTH  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [15:0] in_score,
  input  logic [31:0]        in_position_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_list_select,
  output logic [2:0]         out_rank,
  output logic signed [15:0] out_entry_score,
  output logic [31:0]        out_entry_tag,
  output logic               out_last
);

  localparam int MAXD = (HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int HIW  = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
  localparam int LIW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int HFW  = $clog2(HIGH_DEPTH + 1);
  localparam int LFW  = $clog2(LOW_DEPTH + 1);

  tbk_pkg::cmd_t   cmd_hi;
  tbk_pkg::cmd_t   cmd_lo;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   rank;
  logic            lst;
  logic            emit;
  logic            last;
  logic            out_free;
  logic [HFW-1:0]  hi_fill;
  logic [LFW-1:0]  lo_fill;
  tbk_pkg::score_t hi_best_score;
  tbk_pkg::score_t lo_best_score;
  tbk_pkg::tag_t   hi_best_tag;
  tbk_pkg::tag_t   lo_best_tag;

  tbk_pkg::score_t in_score_r;
  tbk_pkg::tag_t   in_tag_r;

  logic            out_valid_r, out_valid_nxt;
  logic            out_list_select_r;
  logic [2:0]      out_rank_r;
  tbk_pkg::score_t out_entry_score_r;
  tbk_pkg::tag_t   out_entry_tag_r;
  logic            out_last_r;

  // Hold the record payload for the whole update of both lists.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_score_r <= in_score;
      in_tag_r   <= in_position_tag;
    end
  end

  tbk_ctrl #(
    .HIGH_DEPTH (HIGH_DEPTH),
    .LOW_DEPTH  (LOW_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .out_free    (out_free),
    .hi_fill     (hi_fill),
    .lo_fill     (lo_fill),
    .in_stall    (in_stall),
    .cmd_hi      (cmd_hi),
    .cmd_lo      (cmd_lo),
    .cnt         (cnt),
    .rank        (rank),
    .lst         (lst),
    .emit        (emit),
    .last        (last)
  );

  // High list keeps the largest scores, low list the smallest.
  tbk_list #(
    .DEPTH     (HIGH_DEPTH),
    .KEEP_HIGH (1'b1)
  ) u_high (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_hi),
    .rd_idx     (cnt[HIW-1:0]),
    .wr_rank    (rank[HIW-1:0]),
    .new_score  (in_score_r),
    .new_tag    (in_tag_r),
    .fill       (hi_fill),
    .best_score (hi_best_score),
    .best_tag   (hi_best_tag)
  );

  tbk_list #(
    .DEPTH     (LOW_DEPTH),
    .KEEP_HIGH (1'b0)
  ) u_low (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_lo),
    .rd_idx     (cnt[LIW-1:0]),
    .wr_rank    (rank[LIW-1:0]),
    .new_score  (in_score_r),
    .new_tag    (in_tag_r),
    .fill       (lo_fill),
    .best_score (lo_best_score),
    .best_tag   (lo_best_tag)
  );

  // Output register: free when empty or draining this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result picked by the last scan; rank wraps to three bits.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_list_select_r <= lst;
      out_rank_r        <= 3'(rank);
      out_entry_score_r <= lst ? lo_best_score : hi_best_score;
      out_entry_tag_r   <= lst ? lo_best_tag : hi_best_tag;
      out_last_r        <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_list_select = out_list_select_r;
  assign out_rank        = out_rank_r;
  assign out_entry_score = out_entry_score_r;
  assign out_entry_tag   = out_entry_tag_r;
  assign out_last        = out_last_r;

endmodule

// ----- hw/rtl/tbk_list.sv -----
module tbk_list #(
  parameter int DEPTH     = 8,
  parameter bit KEEP_HIGH = 1'b1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbk_pkg::cmd_t                  cmd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_rank,
  input  tbk_pkg::score_t                new_score,
  input  tbk_pkg::tag_t                  new_tag,
  output logic [$clog2(DEPTH + 1)-1:0]   fill,
  output tbk_pkg::score_t                best_score,
  output tbk_pkg::tag_t                  best_tag
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(2 * DEPTH);

  // Two banks: the live one and a spare that receives the sorted copy.
  tbk_pkg::score_t mem_score [0:2*DEPTH-1];
  tbk_pkg::tag_t   mem_tag   [0:2*DEPTH-1];

  logic            bank_r;
  logic [FW-1:0]   fill_r;
  logic [DEPTH-1:0] mark_r;

  logic            rd_vld_r;
  logic            rd_strong_r;
  logic [IW-1:0]   rd_idx_r;
  tbk_pkg::score_t rd_score_r;
  tbk_pkg::tag_t   rd_tag_r;

  logic            trk_vld_r;
  logic [IW-1:0]   best_idx_r;
  tbk_pkg::score_t best_score_r;
  tbk_pkg::tag_t   best_tag_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  tbk_pkg::score_t wr_score;
  tbk_pkg::tag_t   wr_tag;
  logic [AW-1:0]   rd_addr;
  logic            elig;
  logic            take;

  function automatic logic [AW-1:0] addr_of(input logic bank, input logic [IW-1:0] idx);
    addr_of = bank ? (AW'(DEPTH) + AW'(idx)) : AW'(idx);
  endfunction

  assign rd_addr = addr_of(bank_r, rd_idx);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = addr_of(bank_r, fill_r[IW-1:0]);
    wr_score = new_score;
    wr_tag   = new_tag;
    if (cmd.wr_append) begin
      wr_en = 1'b1;
    end else if (cmd.wr_repl) begin
      wr_en   = tbk_pkg::beats(KEEP_HIGH, new_score, best_score_r);
      wr_addr = addr_of(bank_r, best_idx_r);
    end else if (cmd.wr_sorted) begin
      wr_en    = 1'b1;
      wr_addr  = addr_of(~bank_r, wr_rank);
      wr_score = best_score_r;
      wr_tag   = best_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_score[wr_addr] <= wr_score;
      mem_tag[wr_addr]   <= wr_tag;
    end
    if (cmd.rd_en) begin
      rd_score_r <= mem_score[rd_addr];
      rd_tag_r   <= mem_tag[rd_addr];
    end
  end

  // Strict compares keep the lowest slot on ties in both scan modes.
  assign elig = !rd_strong_r || !mark_r[rd_idx_r];
  assign take = rd_vld_r && elig &&
                (!trk_vld_r ||
                 (rd_strong_r ? tbk_pkg::beats(KEEP_HIGH, rd_score_r, best_score_r)
                              : tbk_pkg::beats(KEEP_HIGH, best_score_r, rd_score_r)));

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx;
    rd_strong_r <= cmd.pick_top;
    if (take) begin
      best_idx_r   <= rd_idx_r;
      best_score_r <= rd_score_r;
      best_tag_r   <= rd_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= 1'b0;
      fill_r    <= '0;
      mark_r    <= '0;
      rd_vld_r  <= 1'b0;
      trk_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.scan_clr) begin
        trk_vld_r <= 1'b0;
      end else if (take) begin
        trk_vld_r <= 1'b1;
      end
      if (cmd.wr_append) begin
        fill_r <= fill_r + FW'(1);
      end
      if (cmd.swap) begin
        bank_r <= ~bank_r;
        mark_r <= '0;
      end else if (cmd.wr_sorted) begin
        mark_r[best_idx_r] <= 1'b1;
      end
    end
  end

  assign fill       = fill_r;
  assign best_score = best_score_r;
  assign best_tag   = best_tag_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill count beyond depth");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_append |-> (fill_r < FW'(DEPTH)))
    else $error("append on a full list");

  a_sorted_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sorted |-> (trk_vld_r && !mark_r[best_idx_r]))
    else $error("sorted copy of an empty or already placed entry");

endmodule

// ----- hw/rtl/tbk_ctrl.sv -----
module tbk_ctrl #(
  parameter int HIGH_DEPTH = 8,
  parameter int LOW_DEPTH  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  input  logic          out_free,
  input  logic [$clog2(HIGH_DEPTH + 1)-1:0] hi_fill,
  input  logic [$clog2(LOW_DEPTH + 1)-1:0]  lo_fill,
  output logic          in_stall,
  output tbk_pkg::cmd_t cmd_hi,
  output tbk_pkg::cmd_t cmd_lo,
  output logic [$clog2(((HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH) + 1)-1:0] cnt,
  output logic [$clog2(((HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH) + 1)-1:0] rank,
  output logic          lst,
  output logic          emit,
  output logic          last
);

  localparam int MAXD = (HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int HFW  = $clog2(HIGH_DEPTH + 1);
  localparam int LFW  = $clog2(LOW_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_REPL   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_SWAP   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic          lst_r, lst_nxt;
  logic          dump_r, dump_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rank_r, rank_nxt;

  tbk_pkg::cmd_t cmd;
  logic [CW-1:0] lim;
  logic          full;
  logic          done_list;

  assign lim  = lst_r ? CW'(lo_fill) : CW'(hi_fill);
  assign full = lst_r ? (lo_fill == LFW'(LOW_DEPTH)) : (hi_fill == HFW'(HIGH_DEPTH));

  always_comb begin
    state_nxt = state_r;
    lst_nxt   = lst_r;
    dump_nxt  = dump_r;
    cnt_nxt   = cnt_r;
    rank_nxt  = rank_r;
    cmd       = '0;
    emit      = 1'b0;
    last      = 1'b0;
    done_list = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dump_nxt  = in_req_type;
          lst_nxt   = 1'b0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cnt_nxt  = '0;
        rank_nxt = '0;
        if (dump_r) begin
          if (lim == '0) begin
            done_list = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          state_nxt = full ? S_SCAN : S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.wr_append = 1'b1;
        done_list     = 1'b1;
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.pick_top = dump_r;
        cmd.scan_clr = (cnt_r == '0);
        if (cnt_r == lim - CW'(1)) begin
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_WAIT: begin
        state_nxt = dump_r ? S_EMIT : S_REPL;
      end
      S_REPL: begin
        cmd.wr_repl = 1'b1;
        done_list   = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          emit          = 1'b1;
          cmd.wr_sorted = 1'b1;
          last          = (rank_r == lim - CW'(1)) && (lst_r || (lo_fill == '0));
          if (rank_r == lim - CW'(1)) begin
            state_nxt = S_SWAP;
          end else begin
            rank_nxt  = rank_r + CW'(1);
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SWAP: begin
        cmd.swap  = 1'b1;
        done_list = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (done_list) begin
      if (lst_r) begin
        state_nxt = S_IDLE;
      end else begin
        lst_nxt   = 1'b1;
        state_nxt = S_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lst_r   <= 1'b0;
      dump_r  <= 1'b0;
      cnt_r   <= '0;
      rank_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lst_r   <= lst_nxt;
      dump_r  <= dump_nxt;
      cnt_r   <= cnt_nxt;
      rank_r  <= rank_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd_hi   = lst_r ? '0 : cmd;
  assign cmd_lo   = lst_r ? cmd : '0;
  assign cnt      = cnt_r;
  assign rank     = rank_r;
  assign lst      = lst_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result issued into an occupied output register");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r < lim))
    else $error("scan index past fill count");

  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPEND) |-> !full)
    else $error("append chosen for a full list");

endmodule

// ----- test/tb_top_bottom_k_score_tracker.sv -----
`timescale 1ns / 1ps

module tb_top_bottom_k_score_tracker;

  // Both lists share one depth here, which keeps the predictor's arrays uniform.
  localparam int SLOTS = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  // Covers a record on full lists (two scans) plus the idle-to-start step.
  localparam int DRAIN_CYCLES = 64;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_DUMP   = 1'b1;
  localparam logic LIST_HIGH  = 1'b0;
  localparam logic LIST_LOW   = 1'b1;

  typedef struct packed {
    logic            list_select;
    logic [2:0]      rank;
    tbk_pkg::score_t entry_score;
    tbk_pkg::tag_t   entry_tag;
    logic            last;
  } dump_entry_t;

  // Mirror of the two lists plus the dump entries still owed by the block.
  class rank_book;
    tbk_pkg::score_t hi_sc[SLOTS];
    tbk_pkg::tag_t   hi_tg[SLOTS];
    int unsigned     hi_cnt;
    tbk_pkg::score_t lo_sc[SLOTS];
    tbk_pkg::tag_t   lo_tg[SLOTS];
    int unsigned     lo_cnt;
    dump_entry_t     owed[$];
    int unsigned     errors;

    function new();
      hi_cnt = 0;
      lo_cnt = 0;
      errors = 0;
    endfunction

    // Stable insertion sort of one list, left in place like the block's store.
    function void sort_list(bit keep_high);
      tbk_pkg::score_t s[SLOTS];
      tbk_pkg::tag_t   t[SLOTS];
      int unsigned     n;
      tbk_pkg::score_t ks;
      tbk_pkg::tag_t   kt;
      int              j;
      if (keep_high) begin
        s = hi_sc; t = hi_tg; n = hi_cnt;
      end else begin
        s = lo_sc; t = lo_tg; n = lo_cnt;
      end
      for (int i = 1; i < int'(n); i++) begin
        ks = s[i];
        kt = t[i];
        j = i;
        while (j > 0 && (keep_high ? (s[j-1] < ks) : (s[j-1] > ks))) begin
          s[j] = s[j-1];
          t[j] = t[j-1];
          j--;
        end
        s[j] = ks;
        t[j] = kt;
      end
      if (keep_high) begin
        hi_sc = s; hi_tg = t;
      end else begin
        lo_sc = s; lo_tg = t;
      end
    endfunction

    function void apply_item(logic req, tbk_pkg::score_t sc, tbk_pkg::tag_t tg);
      int          worst;
      int unsigned before_cnt;
      dump_entry_t e;
      if (req == REQ_RECORD) begin
        if (hi_cnt < SLOTS) begin
          hi_sc[hi_cnt] = sc;
          hi_tg[hi_cnt] = tg;
          hi_cnt++;
        end else begin
          worst = 0;
          for (int i = 1; i < SLOTS; i++) if (hi_sc[i] < hi_sc[worst]) worst = i;
          if (sc > hi_sc[worst]) begin
            hi_sc[worst] = sc;
            hi_tg[worst] = tg;
          end
        end
        if (lo_cnt < SLOTS) begin
          lo_sc[lo_cnt] = sc;
          lo_tg[lo_cnt] = tg;
          lo_cnt++;
        end else begin
          worst = 0;
          for (int i = 1; i < SLOTS; i++) if (lo_sc[i] > lo_sc[worst]) worst = i;
          if (sc < lo_sc[worst]) begin
            lo_sc[worst] = sc;
            lo_tg[worst] = tg;
          end
        end
      end else begin
        sort_list(1'b1);
        sort_list(1'b0);
        before_cnt = owed.size();
        for (int i = 0; i < int'(hi_cnt); i++) begin
          e = '{LIST_HIGH, 3'(i), hi_sc[i], hi_tg[i], 1'b0};
          owed.push_back(e);
        end
        for (int i = 0; i < int'(lo_cnt); i++) begin
          e = '{LIST_LOW, 3'(i), lo_sc[i], lo_tg[i], 1'b0};
          owed.push_back(e);
        end
        if (owed.size() > before_cnt) owed[owed.size()-1].last = 1'b1;
      end
    endfunction

    function void check_entry(dump_entry_t got);
      dump_entry_t want;
      if (owed.size() == 0) begin
        $error("unexpected dump entry: list %0d rank %0d score %0d tag %0h",
               got.list_select, got.rank, got.entry_score, got.entry_tag);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.list_select !== want.list_select) begin
        $error("list_select mismatch: expected %0d, got %0d", want.list_select, got.list_select);
        errors++;
      end
      if (got.rank !== want.rank) begin
        $error("rank mismatch: expected %0d, got %0d", want.rank, got.rank);
        errors++;
      end
      if (got.entry_score !== want.entry_score) begin
        $error("entry_score mismatch: expected %0d, got %0d", want.entry_score, got.entry_score);
        errors++;
      end
      if (got.entry_tag !== want.entry_tag) begin
        $error("entry_tag mismatch: expected %0h, got %0h", want.entry_tag, got.entry_tag);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_req_type = REQ_RECORD;
  tbk_pkg::score_t in_score = '0;
  tbk_pkg::tag_t   in_position_tag = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            out_list_select;
  logic [2:0]      out_rank;
  tbk_pkg::score_t out_entry_score;
  tbk_pkg::tag_t   out_entry_tag;
  logic            out_last;

  // Idle and stall rates in percent; the main flow changes them per phase.
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         hold_arm = 1'b0;
  logic         hold_on = 1'b0;
  int unsigned  cycle_count = 0;
  rank_book     book;

  top_bottom_k_score_tracker #(
    .HIGH_DEPTH (SLOTS),
    .LOW_DEPTH  (SLOTS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_score        (in_score),
    .in_position_tag (in_position_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_list_select (out_list_select),
    .out_rank        (out_rank),
    .out_entry_score (out_entry_score),
    .out_entry_tag   (out_entry_tag),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Long receiver hold-off, counted here on rising edges so the stall driver
  // at the falling edge always sees a settled flag.
  initial begin
    wait (hold_arm);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // Receiver: stall at the current rate, or solid while the hold-off runs.
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  // Check every dump entry the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_entry('{out_list_select, out_rank, out_entry_score, out_entry_tag,
                         out_last});
    end
  end

  // Offer one item and hold it until taken. Call and return at a falling edge.
  task automatic send_item(input logic req, input tbk_pkg::score_t sc,
                           input tbk_pkg::tag_t tg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_score        <= sc;
    in_position_tag <= tg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.apply_item(req, sc, tg);
    @(negedge clk);
  endtask

  // Mix narrow ranges (lots of ties), the extremes and full-range scores.
  function automatic tbk_pkg::score_t pick_score();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 25) return tbk_pkg::score_t'($urandom);
    if (mode < 50) return tbk_pkg::score_t'($signed($urandom_range(8)) - 4);
    if (mode < 65) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh8001;
        default: return 16'sh7ffe;
      endcase
    end
    return tbk_pkg::score_t'($signed($urandom_range(2000)) - 1000);
  endfunction

  // Mostly records with the odd dump; dump payload is junk and toggles too.
  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(REQ_DUMP, tbk_pkg::score_t'($urandom), $urandom);
      else send_item(REQ_RECORD, pick_score(), $urandom);
    end
  endtask

  initial begin
    book = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, no idling.
    // Dump with both lists empty: nothing should come out.
    send_item(REQ_DUMP, 16'sh7fff, 32'hffff_ffff);
    // Extremes of score and tag, then a short dump.
    send_item(REQ_RECORD, 16'sh7fff, 32'hffff_ffff);
    send_item(REQ_RECORD, 16'sh8000, 32'h0000_0000);
    send_item(REQ_DUMP, 16'sh0000, 32'h0000_0000);
    // Fill both lists, with a tie at 100.
    send_item(REQ_RECORD, 16'sd0, 32'h0000_0010);
    send_item(REQ_RECORD, -16'sd1, 32'h0000_0011);
    send_item(REQ_RECORD, 16'sd1, 32'h0000_0012);
    send_item(REQ_RECORD, 16'sd100, 32'h0000_0013);
    send_item(REQ_RECORD, 16'sd100, 32'h0000_0014);
    send_item(REQ_RECORD, -16'sd100, 32'h0000_0015);
    // Lists full: replace the weakest entry in each.
    send_item(REQ_RECORD, 16'sd5, 32'h0000_0016);
    // Each equals the current worst of one list, which must not change; the other list takes it in.
    send_item(REQ_RECORD, -16'sd100, 32'h0000_0017);
    send_item(REQ_RECORD, 16'sd100, 32'h0000_0018);
    send_item(REQ_DUMP, 16'sh5555, 32'haaaa_aaaa);
    // Pile up ties so the sort has to keep slot order.
    send_item(REQ_RECORD, 16'sd7, 32'h0000_0020);
    send_item(REQ_RECORD, 16'sd7, 32'h0000_0021);
    send_item(REQ_RECORD, 16'sd7, 32'h0000_0022);
    send_item(REQ_RECORD, 16'sd7, 32'h0000_0023);
    send_item(REQ_RECORD, 16'sh8000, 32'h8000_0000);
    send_item(REQ_RECORD, 16'sh7fff, 32'h7fff_ffff);
    send_item(REQ_DUMP, 16'shaaaa, 32'h5555_5555);
    // Dump again straight away: the store is already sorted.
    send_item(REQ_DUMP, 16'sh0000, 32'h0000_0000);

    // Random phase: no idling. Partway through, hold the receiver off while
    // a dump and a run of records keep coming, so the block backs up.
    run_random(20);
    hold_arm = 1'b1;
    send_item(REQ_DUMP, tbk_pkg::score_t'($urandom), $urandom);
    run_random(12);
    run_random(10);

    // Sender idle most of the time.
    send_idle_pct = 63;
    run_random(42);

    // Receiver stalling most of the time.
    send_idle_pct = 0;
    recv_stall_pct = 63;
    run_random(42);

    // Light idling on both sides, then finish with a dump.
    send_idle_pct = 18;
    recv_stall_pct = 18;
    run_random(20);
    send_item(REQ_DUMP, tbk_pkg::score_t'($urandom), $urandom);
    in_valid <= 1'b0;

    // Drain: wait for every owed entry, then let the block settle.
    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tbk_pkg.sv
hw/rtl/tbk_list.sv
hw/rtl/tbk_ctrl.sv
hw/rtl/top_bottom_k_score_tracker.sv
test/tb_top_bottom_k_score_tracker.sv
